// ===== sv/assert_macros.svh =====
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define TFD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define TFD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== sv/tfd_pkg.sv =====
// Package with widths, constants and mode codes of the fall detector.
package tfd_pkg;
    localparam int AccelBitsDef     = 16;
    localparam int CountBitsDef     = 16;
    localparam int VelocityBitsDef  = 48;
    localparam int LyingFracDef     = 179;
    localparam int GravityCodeDef   = 2511;

    localparam int CfgIdxBits = 3;
    localparam int CfgDataBits = 40;

    localparam logic [CfgIdxBits-1:0] RegLowThr   = 3'd0;
    localparam logic [CfgIdxBits-1:0] RegHighThr  = 3'd1;
    localparam logic [CfgIdxBits-1:0] RegTroughWin = 3'd2;
    localparam logic [CfgIdxBits-1:0] RegVelThr   = 3'd3;
    localparam logic [CfgIdxBits-1:0] RegPostStart = 3'd4;
    localparam logic [CfgIdxBits-1:0] RegPostEnd  = 3'd5;
    localparam logic [CfgIdxBits-1:0] RegLyingCos = 3'd6;
    localparam logic [CfgIdxBits-1:0] RegTurnCos  = 3'd7;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_TROUGH  = 2'd1,
        MODE_IMPACT  = 2'd2,
        MODE_POSTURE = 2'd3
    } t_mode;

    typedef struct packed {
        logic [16:0] low_thr;
        logic [16:0] high_thr;
        logic [15:0] trough_win;
        logic [39:0] vel_thr;
        logic [15:0] post_start;
        logic [15:0] post_end;
        logic signed [15:0] lying_cos;
        logic signed [15:0] turn_cos;
    } t_cfg;
endpackage

// ===== sv/tfd_isqrt.sv =====
// Bit-serial integer square root, one result bit per cycle.
module tfd_isqrt #(
    parameter int IN_BITS = 50
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [IN_BITS-1:0]        i_value,
    output logic                      o_done,
    output logic [(IN_BITS+1)/2-1:0]  o_root
);
    localparam int RBits = (IN_BITS + 1) / 2;
    localparam int VBits = 2 * RBits;
    localparam int CBits = $clog2(RBits + 1);

    logic [VBits-1:0] r_val, n_val;
    logic [RBits+1:0] r_rem, n_rem;
    logic [RBits-1:0] r_root, n_root;
    logic [CBits-1:0] r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [RBits+1:0] trial;

    always_comb begin
        n_val  = r_val;
        n_rem  = r_rem;
        n_root = r_root;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        trial  = '0;
        if (i_start) begin
            n_val  = VBits'(i_value);
            n_rem  = '0;
            n_root = '0;
            n_cnt  = CBits'(RBits);
            n_busy = 1'b1;
        end else if (r_busy) begin
            // Bring down two bits and try the next root bit.
            n_rem = {r_rem[RBits-1:0], r_val[VBits-1 -: 2]};
            n_val = {r_val[VBits-3:0], 2'b00};
            trial = {r_root, 2'b01};
            if (n_rem >= trial) begin
                n_rem  = n_rem - trial;
                n_root = {r_root[RBits-2:0], 1'b1};
            end else begin
                n_root = {r_root[RBits-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CBits'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_val  <= n_val;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

// ===== sv/tfd_mul.sv =====
// Registered signed multiplier shared by the sequencer's vector, velocity and angle products.
module tfd_mul #(
    parameter int A_BITS = 33,
    parameter int B_BITS = 33
) (
    input  logic                            i_clk,
    input  logic signed [A_BITS-1:0]        i_a,
    input  logic signed [B_BITS-1:0]        i_b,
    output logic signed [A_BITS+B_BITS-1:0] o_p
);
    logic signed [A_BITS+B_BITS-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;
endmodule

// ===== sv/tfd_cfg.sv =====
// Configuration register file of the fall detector.
module tfd_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [tfd_pkg::CfgIdxBits-1:0] i_cfg_index,
    input  logic [tfd_pkg::CfgDataBits-1:0] i_cfg_data,
    output tfd_pkg::t_cfg                  o_cfg
);
    import tfd_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.low_thr    <= 17'd1536;
            r_cfg.high_thr   <= 17'd6400;
            r_cfg.trough_win <= 16'd500;
            r_cfg.vel_thr    <= 40'd179200;
            r_cfg.post_start <= 16'd1000;
            r_cfg.post_end   <= 16'd3000;
            r_cfg.lying_cos  <= 16'sd23170;
            r_cfg.turn_cos   <= 16'sd23170;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                RegLowThr:    r_cfg.low_thr    <= i_cfg_data[16:0];
                RegHighThr:   r_cfg.high_thr   <= i_cfg_data[16:0];
                RegTroughWin: r_cfg.trough_win <= i_cfg_data[15:0];
                RegVelThr:    r_cfg.vel_thr    <= i_cfg_data[39:0];
                RegPostStart: r_cfg.post_start <= i_cfg_data[15:0];
                RegPostEnd:   r_cfg.post_end   <= i_cfg_data[15:0];
                RegLyingCos:  r_cfg.lying_cos  <= i_cfg_data[15:0];
                RegTurnCos:   r_cfg.turn_cos   <= i_cfg_data[15:0];
                default:      r_cfg <= r_cfg;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;
endmodule

// ===== sv/threshold_fall_detector.sv =====
// Top level of the threshold fall detector: sequencer around shared root and multiplier.
// Each accepted sample is processed by a sequencer that reuses one bit-serial
// square-root unit and one registered 33x33 multiplier. The result beat is raised
// after the squares and one root in idle mode, in impact mode and for a posture
// sample before the counting window. A trough sample or a counted posture sample
// first adds its velocity or lying product. The posture decision sample needs two
// roots and several products. The root unit sets most of the run time: it works at
// one bit a cycle and then reports. A new sample can be taken at the edge after the
// one that raises the result. A result that the receiver has not yet taken holds
// back only the next result. tdata in: accel_x, accel_y, accel_z, time_ms from bit 0
// up; tdata out: fall_flag at bit 0, mode_now at bits 2:1. Configuration writes take
// effect at once and belong only between samples.
module threshold_fall_detector #(
    parameter int COUNT_BITS        = tfd_pkg::CountBitsDef,
    parameter int VELOCITY_BITS     = tfd_pkg::VelocityBitsDef,
    parameter int LYING_FRACTION_Q8 = tfd_pkg::LyingFracDef,
    parameter int GRAVITY_CODE      = tfd_pkg::GravityCodeDef
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // accel_x, accel_y, accel_z, time_ms from the lowest bit up, zero padded.
    input  logic [((3*tfd_pkg::AccelBitsDef+32+7)/8)*8-1:0] s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // fall_flag, mode_now from the lowest bit up, zero padded.
    output logic [7:0]                      m_axis_tdata,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [tfd_pkg::CfgIdxBits-1:0]  i_cfg_index,
    input  logic [tfd_pkg::CfgDataBits-1:0] i_cfg_data
);
    import tfd_pkg::*;

    localparam int AB = AccelBitsDef;
    localparam int SqBits = 2 * AB + 2;
    localparam int RootBits = (SqBits + 1) / 2;
    localparam int MulW = 33;
    localparam int PW = 2 * MulW;
    localparam int VB = VELOCITY_BITS;
    localparam int SumW = ((VB > 49) ? VB : 49) + 2;
    localparam int CB = COUNT_BITS;
    localparam logic [CB-1:0] CountMax = {CB{1'b1}};

    typedef enum logic [3:0] {
        S_IDLE, S_SQ, S_ROOT, S_DISPATCH, S_VEL, S_LYING, S_PRESQ, S_PREROOT,
        S_NN, S_TURN, S_DOT, S_DECIDE, S_OUT
    } t_state;

    t_cfg cfg;

    tfd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    t_state r_state;
    logic [2:0] r_step;
    t_mode  r_mode;
    logic signed [AB-1:0] r_a [3];
    logic signed [AB-1:0] r_pre [3];
    logic [31:0] r_t, r_trough_time, r_last_time, r_impact_time;
    logic signed [VB-1:0] r_vel;
    logic r_have_pre;
    logic [CB-1:0] r_ptotal, r_plying;
    logic [SqBits-1:0] r_acc;
    logic [RootBits-1:0] r_mag, r_na;
    logic signed [PW+1:0] r_dot;
    logic signed [PW-1:0] r_nn;
    logic r_lying_duty;
    logic r_fall;
    logic r_out_valid;
    logic [7:0] r_out;

    logic signed [MulW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] mul_p;
    logic sq_start, sq_done;
    logic [SqBits-1:0] sq_in;
    logic [RootBits-1:0] sq_root;

    tfd_mul #(.A_BITS(MulW), .B_BITS(MulW)) u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    tfd_isqrt #(.IN_BITS(SqBits)) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_value (sq_in),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    logic s_fire;
    assign s_fire = s_axis_tvalid && s_axis_tready;
    // A waiting result beat sits in r_out, so only the sequencer gates the input.
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;
    assign sq_in = r_acc;

    // Multiplier operand selection; the product arrives in the cycle after its operands.
    logic [31:0] dt, since_tr, since_imp;
    assign dt        = r_t - r_last_time;
    assign since_tr  = r_t - r_trough_time;
    assign since_imp = r_t - r_impact_time;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        sq_start = 1'b0;
        unique case (r_state) inside
            S_SQ, S_PRESQ, S_DOT: begin
                if (r_step < 3'd3) begin
                    mul_a = MulW'(r_state == S_PRESQ ? r_pre[r_step[1:0]]
                                                     : r_a[r_step[1:0]]);
                    mul_b = MulW'(r_state == S_SQ ? r_a[r_step[1:0]] : r_pre[r_step[1:0]]);
                    if (r_state == S_DOT) mul_b = MulW'(r_pre[r_step[1:0]]);
                    if (r_state == S_DOT) mul_a = MulW'(r_a[r_step[1:0]]);
                end
                if (r_step == 3'd4 && r_state != S_DOT) sq_start = 1'b1;
            end
            S_VEL: begin
                mul_a = MulW'($signed({1'b0, r_mag}) - $signed(33'(GRAVITY_CODE)));
                mul_b = $signed({1'b0, dt});
            end
            S_LYING: begin
                mul_a = MulW'(cfg.lying_cos);
                mul_b = $signed(MulW'(r_mag));
            end
            S_NN: begin
                mul_a = $signed(MulW'(r_na));
                mul_b = $signed(MulW'(r_mag));
            end
            S_TURN: begin
                mul_a = MulW'(cfg.turn_cos);
                mul_b = r_nn[MulW-1:0];
            end
            default: ;
        endcase
    end

    logic signed [SumW-1:0] vel_sum;
    logic signed [SumW-1:0] vmax_w, vmin_w;
    assign vmax_w = SumW'({(VB-1){1'b1}});
    assign vmin_w = -vmax_w - 1;
    assign vel_sum = SumW'(r_vel) + SumW'(mul_p);

    logic [VB-1:0] vel_abs;
    assign vel_abs = r_vel[VB-1] ? VB'(-r_vel) : VB'(r_vel);
    logic vel_ok;
    assign vel_ok = ((VB+41)'(vel_abs) >= (VB+41)'(cfg.vel_thr)) ||
                    (r_vel == {1'b1, {(VB-1){1'b0}}});

    logic signed [AB+16:0] z_sh;
    assign z_sh = (AB+17)'(r_a[2]) <<< 15;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step <= '0;
            r_mode <= MODE_IDLE;
            r_trough_time <= '0;
            r_last_time <= '0;
            r_impact_time <= '0;
            r_vel <= '0;
            r_have_pre <= 1'b0;
            r_ptotal <= '0;
            r_plying <= '0;
            r_out_valid <= 1'b0;
            r_out <= '0;
            r_fall <= 1'b0;
            for (int i = 0; i < 3; i++) r_pre[i] <= '0;
        end else begin
            if (r_out_valid && m_axis_tready) r_out_valid <= 1'b0;
            unique case (r_state) inside
                S_IDLE: begin
                    if (s_fire) begin
                        r_a[0] <= s_axis_tdata[AB-1:0];
                        r_a[1] <= s_axis_tdata[2*AB-1:AB];
                        r_a[2] <= s_axis_tdata[3*AB-1:2*AB];
                        r_t <= s_axis_tdata[3*AB+31:3*AB];
                        r_fall <= 1'b0;
                        r_step <= '0;
                        r_acc <= '0;
                        r_state <= S_SQ;
                    end
                end
                S_SQ, S_PRESQ: begin
                    r_step <= r_step + 1'b1;
                    if (r_step >= 3'd1 && r_step <= 3'd3) r_acc <= r_acc + SqBits'(mul_p);
                    if (r_step == 3'd4) r_state <= (r_state == S_SQ) ? S_ROOT : S_PREROOT;
                end
                S_ROOT: begin
                    if (sq_done) begin
                        r_mag <= sq_root;
                        r_step <= '0;
                        r_state <= S_DISPATCH;
                    end
                end
                S_DISPATCH: begin
                    r_step <= '0;
                    unique case (r_mode)
                        MODE_IDLE: begin
                            if ((RootBits+17)'(r_mag) < (RootBits+17)'(cfg.low_thr)) begin
                                r_mode <= MODE_TROUGH;
                                r_trough_time <= r_t;
                                r_last_time <= r_t;
                                r_vel <= '0;
                                r_pre <= r_a;
                                r_have_pre <= 1'b1;
                            end
                            r_state <= S_OUT;
                        end
                        MODE_TROUGH: r_state <= S_VEL;
                        MODE_IMPACT: begin
                            if (vel_ok) begin
                                r_ptotal <= '0;
                                r_plying <= '0;
                                r_mode <= MODE_POSTURE;
                            end else begin
                                r_mode <= MODE_IDLE;
                            end
                            r_state <= S_OUT;
                        end
                        default: begin
                            if (since_imp < 32'(cfg.post_start)) begin
                                r_state <= S_OUT;
                            end else if (since_imp > 32'(cfg.post_end)) begin
                                r_lying_duty <= (r_ptotal != '0) &&
                                    ((CB+9)'(r_plying) * (CB+9)'(256) >=
                                     (CB+9)'(LYING_FRACTION_Q8) * (CB+9)'(r_ptotal));
                                r_acc <= '0;
                                r_state <= S_PRESQ;
                            end else begin
                                r_ptotal <= (r_ptotal == CountMax) ? r_ptotal : r_ptotal + 1'b1;
                                r_state <= S_LYING;
                            end
                        end
                    endcase
                end
                S_VEL: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == 3'd1) begin
                        if (vel_sum > vmax_w) r_vel <= vmax_w[VB-1:0];
                        else if (vel_sum < vmin_w) r_vel <= vmin_w[VB-1:0];
                        else r_vel <= vel_sum[VB-1:0];
                        r_last_time <= r_t;
                        if ((RootBits+17)'(r_mag) > (RootBits+17)'(cfg.high_thr)) begin
                            if (since_tr <= 32'(cfg.trough_win)) begin
                                r_impact_time <= r_t;
                                r_mode <= MODE_IMPACT;
                            end else begin
                                r_mode <= MODE_IDLE;
                            end
                        end else if (since_tr > 32'(cfg.trough_win)) begin
                            r_mode <= MODE_IDLE;
                        end
                        r_state <= S_OUT;
                    end
                end
                S_LYING: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == 3'd1) begin
                        if (r_mag != '0 && PW'(z_sh) < mul_p)
                            r_plying <= (r_plying == CountMax) ? r_plying : r_plying + 1'b1;
                        r_state <= S_OUT;
                    end
                end
                S_PREROOT: begin
                    if (sq_done) begin
                        r_na <= sq_root;
                        r_step <= '0;
                        r_state <= S_NN;
                    end
                end
                S_NN: begin
                    if (r_step == 3'd1) begin
                        r_nn <= mul_p;
                        r_step <= '0;
                        r_dot <= '0;
                        r_state <= S_DOT;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                S_DOT: begin
                    if (r_step >= 3'd1 && r_step <= 3'd3) r_dot <= r_dot + (PW+2)'(mul_p);
                    if (r_step == 3'd3) begin
                        r_step <= '0;
                        r_state <= S_TURN;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                S_TURN: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == 3'd1) r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    // Changed when dot*32768 < turn_cos*|pre|*|a|; a zero vector means unchanged.
                    if (r_lying_duty) begin
                        if (!r_have_pre) r_fall <= 1'b1;
                        else if (r_na != '0 && r_mag != '0 &&
                                 ((PW+17)'(r_dot) <<< 15) < (PW+17)'(mul_p))
                            r_fall <= 1'b1;
                    end
                    r_mode <= MODE_IDLE;
                    r_have_pre <= 1'b0;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_valid) begin
                        r_out <= {5'b0, r_mode, r_fall};
                        r_out_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== sv/tfd_checker.sv =====
// Port-level checker for the fall detector and its bind.
`include "assert_macros.svh"
module tfd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);
    logic out_stall, in_fire, out_fall;
    assign out_stall = m_axis_tvalid && !m_axis_tready;
    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign out_fall  = m_axis_tvalid && m_axis_tdata[0];

    `TFD_ASSERT_NXT(a_out_holds, i_clk, i_rst_n, out_stall, m_axis_tvalid && $stable(m_axis_tdata), "result beat changed while stalled")
    `TFD_ASSERT_IMP(a_fall_idle, i_clk, i_rst_n, out_fall, m_axis_tdata[2:1] == 2'd0, "fall outside idle")
    `TFD_ASSERT_NXT(a_busy_after_in, i_clk, i_rst_n, in_fire, !s_axis_tready, "second beat taken at once")
endmodule

bind threshold_fall_detector tfd_checker u_tfd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
